// ----- src/rtwt_pkg.sv -----
// shared types and constants for the roff text word tokenizer
// parser mode codes, character codes, word length limit and the state record
package rtwt_pkg;

  localparam int unsigned MAX_WORD = 199;

  localparam logic [2:0] M_LINE_START = 3'd0;
  localparam logic [2:0] M_DOT_LINE   = 3'd1;
  localparam logic [2:0] M_NORMAL     = 3'd2;
  localparam logic [2:0] M_HYPHEN     = 3'd3;
  localparam logic [2:0] M_ESC        = 3'd4;
  localparam logic [2:0] M_FONT       = 3'd5;
  localparam logic [2:0] M_SIZE       = 3'd6;

  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_HYPHEN = 8'h2d;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5a;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7a;

  localparam logic [7:0] MAX_COUNT = 8'(MAX_WORD);

  typedef struct packed {
    logic [2:0] mode;
    logic       in_word;
    logic [7:0] count;
    logic       ovf;
  } tok_state_t;

  typedef struct packed {
    logic       emit;
    logic [6:0] letter;
    logic       word_end;
    logic       truncated;
  } tok_result_t;

endpackage

// ----- src/roff_text_word_tokenizer.sv -----
// roff text word tokenizer: strips markup and emits lower-case word letters and end marks
// path: an accepted byte is captured in the input register, then its result in the output register
// throughput: one byte per cycle while out_stall does not hold the output register
// reset: synchronous, clears the parser to line start, drops any open word, empties both registers
// depends on rtwt_pkg and rtwt_step
module roff_text_word_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] text_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] letter,
  output logic       word_end,
  output logic       truncated
);
  import rtwt_pkg::*;

  logic        s1_valid;
  logic        s1_kind;
  logic [7:0]  s1_byte;
  tok_state_t  st;
  tok_state_t  st_next;
  tok_result_t res;
  logic        out_free;
  logic        advance;

  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  rtwt_step u_step (
    .st        (st),
    .kind      (s1_kind),
    .text_byte (s1_byte),
    .st_next   (st_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
      st.mode    <= M_LINE_START;
      st.in_word <= 1'b0;
      st.count   <= '0;
      st.ovf     <= 1'b0;
    end else begin
      if (!in_stall) s1_valid <= in_valid;
      if (advance) st <= st_next;
      if (out_free) out_valid <= advance && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_kind <= kind;
      s1_byte <= text_byte;
    end
    if (out_free) begin
      letter    <= res.letter;
      word_end  <= res.word_end;
      truncated <= res.truncated;
    end
  end

endmodule

// ----- src/rtwt_step.sv -----
// next-state and result logic for one byte of the tokenizer
// depends on rtwt_pkg for mode codes, character codes and the state record
module rtwt_step (
  input  rtwt_pkg::tok_state_t  st,
  input  logic                  kind,
  input  logic [7:0]            text_byte,
  output rtwt_pkg::tok_state_t  st_next,
  output rtwt_pkg::tok_result_t res
);
  import rtwt_pkg::*;

  always_comb begin
    logic take;
    logic norm;
    logic upper;
    logic lower;
    take    = 1'b0;
    norm    = 1'b0;
    upper   = (text_byte >= CH_UA) && (text_byte <= CH_UZ);
    lower   = (text_byte >= CH_LA) && (text_byte <= CH_LZ);
    st_next = st;
    res     = '0;

    if (kind) begin
      st_next.mode = M_NORMAL;
      if (st.in_word) begin
        res.emit      = 1'b1;
        res.word_end  = 1'b1;
        res.truncated = st.ovf;
        st_next.in_word = 1'b0;
        st_next.count   = '0;
        st_next.ovf     = 1'b0;
      end
    end else begin
      unique case (st.mode)
        M_LINE_START: begin
          if (text_byte == CH_DOT) begin
            st_next.mode = M_DOT_LINE;
          end else begin
            st_next.mode = M_NORMAL;
            norm = 1'b1;
          end
        end
        M_DOT_LINE: begin
          if (text_byte == CH_NL) st_next.mode = M_LINE_START;
        end
        M_HYPHEN: begin
          st_next.mode = M_NORMAL;
          take = (text_byte != CH_NL);
        end
        M_ESC: begin
          if (text_byte == CH_F) begin
            st_next.mode = M_FONT;
          end else if (text_byte == CH_S) begin
            st_next.mode = M_SIZE;
          end else begin
            st_next.mode = M_NORMAL;
            take = 1'b1;
          end
        end
        M_FONT: begin
          st_next.mode = M_NORMAL;
        end
        M_SIZE: begin
          if (!((text_byte >= CH_0) && (text_byte <= CH_9))) begin
            st_next.mode = M_NORMAL;
            take = 1'b1;
          end
        end
        default: begin
          st_next.mode = M_NORMAL;
          norm = 1'b1;
        end
      endcase

      // mid-line byte handling
      if (norm) begin
        priority if (text_byte == CH_NL) begin
          st_next.mode = M_LINE_START;
          take = 1'b1;
        end else if (text_byte == CH_HYPHEN) begin
          st_next.mode = M_HYPHEN;
        end else if (text_byte == CH_APOS) begin
          take = 1'b0;
        end else if (text_byte == CH_BSLASH) begin
          st_next.mode = M_ESC;
        end else begin
          take = 1'b1;
        end
      end

      // word assembler
      if (take) begin
        if (upper || lower) begin
          st_next.in_word = 1'b1;
          if (!st.in_word) begin
            st_next.count = '0;
            st_next.ovf   = 1'b0;
          end
          if (st_next.count < MAX_COUNT) begin
            st_next.count = st_next.count + 8'd1;
            res.emit      = 1'b1;
            res.letter    = text_byte[6:0] | 7'h20;
          end else begin
            st_next.ovf = 1'b1;
          end
        end else if (st.in_word) begin
          res.emit        = 1'b1;
          res.word_end    = 1'b1;
          res.truncated   = st.ovf;
          st_next.in_word = 1'b0;
          st_next.count   = '0;
          st_next.ovf     = 1'b0;
        end
      end
    end
  end

endmodule

// ----- src/rtwt_checker.sv -----
// port-level checks for the roff text word tokenizer, bound to the top level
// depends only on the top level's ports
module rtwt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       kind,
  input logic [7:0] text_byte,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] letter,
  input logic       word_end,
  input logic       truncated
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable({letter, word_end, truncated}))
    else $error("stalled output transaction changed");

  // end marks carry no letter
  a_end_no_letter: assert property (@(posedge clk) disable iff (rst)
    out_valid && word_end |-> letter == 7'd0)
    else $error("end mark carries a letter");

  // letters are lower case and never flagged
  a_letter_lower: assert property (@(posedge clk) disable iff (rst)
    out_valid && !word_end |-> letter >= 7'h61 && letter <= 7'h7a && !truncated)
    else $error("bad letter transaction");

  // two end marks never follow each other
  a_no_double_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && word_end ##1 out_valid |-> !word_end)
    else $error("empty word end mark");

endmodule

bind roff_text_word_tokenizer rtwt_checker u_rtwt_checker (.*);
